/* rtl/hbd_pkg.sv */
// ----------------------------------------------------------------------------
// hbd_pkg
// Types and constants shared by the 8-bit Huffman decompressor files.
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_CNT_W = 6;

    typedef logic [1:0] t_op;
    localparam t_op OP_START = 2'd0;
    localparam t_op OP_TREE  = 2'd1;
    localparam t_op OP_CODE  = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_RUN       = 3'd0;
    localparam t_status ST_DONE      = 3'd1;
    localparam t_status ST_BAD_HDR   = 3'd2;
    localparam t_status ST_BAD_PTR   = 3'd3;
    localparam t_status ST_SHORT     = 3'd4;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] HDR_TYPE = 8'h28;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_SIZE   = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] header_word;
        logic [8:0]  tree_address;
        logic [7:0]  tree_byte;
        logic [31:0] code_word;
        logic        end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       last;
    } t_out_item;

endpackage

/* rtl/hbd_ram.sv */
// ----------------------------------------------------------------------------
// hbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/huffman_8bit_decompressor.sv */
// ----------------------------------------------------------------------------
// huffman_8bit_decompressor
// Decodes an 8-bit Huffman stream, one code bit per step through the tree.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid/o_in_ready   | hbd_pkg::t_in_item
//  out     | output    | o_out_valid/i_out_ready | hbd_pkg::t_out_item
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Start and tree items pass from idle through the status state to the output.
//  Code words: each code bit is one tree step, and each decoded byte adds a pass
//  through the leaf and fetch states; a word stops early at the output size or
//  an error. The single read port of the tree RAM allows one read per tree step.
//  One item at a time; the next transfer in waits until the status is registered.
//  Reset is synchronous; the tree RAM is not cleared.
//  Output stalls hold the walk at the next byte or status.
// ----------------------------------------------------------------------------
module huffman_8bit_decompressor #(
    parameter int TREE_DEPTH = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  hbd_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output hbd_pkg::t_out_item                   o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hbd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hbd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import hbd_pkg::*;

    localparam int AW = $clog2(TREE_DEPTH);
    localparam int CW = ((AW > 8) ? AW : 8) + 2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_EVAL  = 5'b00100,
        S_LEAF  = 5'b01000,
        S_STAT  = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [23:0]            r_output_size;
    logic [7:0]             r_tree_size;
    logic [AW-1:0]          r_node, n_node;
    logic [23:0]            r_bp, n_bp;
    logic                   r_err, n_err;
    t_status                r_err_code, n_err_code;
    logic                   r_done, n_done;
    logic [WORD_BITS-1:0]   r_word, n_word;
    logic                   r_eos, n_eos;
    logic [BIT_CNT_W-1:0]   r_bits, n_bits;
    t_out_item              r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [7:0]             ram_rdata;
    logic [CW-1:0]          tree_end_raw, tree_end, child;
    logic                   in_xfer, out_free, reached, dir, leaf;
    t_status                held;

    hbd_ram #(
        .WIDTH (8),
        .DEPTH (TREE_DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_data.tree_address[AW-1:0]),
        .i_wdata (i_in_data.tree_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_xfer      = i_in_valid && o_in_ready;
    assign out_free     = !r_out_valid || i_out_ready;
    assign reached      = (r_bp >= r_output_size);
    assign tree_end_raw = CW'({r_tree_size, 1'b0}) + CW'(2);
    assign tree_end     = (tree_end_raw > CW'(TREE_DEPTH)) ? CW'(TREE_DEPTH) : tree_end_raw;
    assign dir          = r_word[WORD_BITS-1];
    assign child        = CW'(r_node) + CW'(dir) + CW'({ram_rdata[5:0], 1'b0})
                          + CW'(2) - CW'(r_node[0]);
    assign leaf         = dir ? ram_rdata[6] : ram_rdata[7];
    assign held         = r_err ? r_err_code : (r_done ? ST_DONE : ST_RUN);

    always_comb begin
        n_state     = r_state;
        n_node      = r_node;
        n_bp        = r_bp;
        n_err       = r_err;
        n_err_code  = r_err_code;
        n_done      = r_done;
        n_word      = r_word;
        n_eos       = r_eos;
        n_bits      = r_bits;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_node;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_STAT;
                    case (i_in_data.operation)
                        OP_START: begin
                            n_node     = AW'(1);
                            n_bp       = '0;
                            n_err      = 1'b0;
                            n_err_code = ST_RUN;
                            n_done     = 1'b0;
                            if (i_in_data.header_word[7:0] != HDR_TYPE ||
                                (i_in_data.header_word[31:8] != 24'd0 &&
                                 i_in_data.header_word[31:8] != r_output_size)) begin
                                n_err      = 1'b1;
                                n_err_code = ST_BAD_HDR;
                            end else if (r_output_size == 24'd0) begin
                                n_done = 1'b1;
                            end
                        end
                        OP_TREE: begin
                            ram_we = (10'(i_in_data.tree_address) < 10'(TREE_DEPTH));
                        end
                        OP_CODE: begin
                            if (!r_err && !r_done) begin
                                n_word  = i_in_data.code_word;
                                n_eos   = i_in_data.end_of_stream;
                                n_bits  = BIT_CNT_W'(WORD_BITS);
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            n_state = S_STAT;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                if (r_bits == '0 || reached) begin
                    if (reached) begin
                        n_done = 1'b1;
                    end else if (r_eos) begin
                        n_err      = 1'b1;
                        n_err_code = ST_SHORT;
                    end
                    n_state = S_STAT;
                end else if (CW'(r_node) >= tree_end) begin
                    n_err      = 1'b1;
                    n_err_code = ST_BAD_PTR;
                    n_state    = S_STAT;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (child >= tree_end) begin
                    n_err      = 1'b1;
                    n_err_code = ST_BAD_PTR;
                    n_state    = S_STAT;
                end else begin
                    // next node and leaf byte both live at the child address
                    ram_re    = 1'b1;
                    ram_raddr = child[AW-1:0];
                    n_word    = r_word << 1;
                    n_bits    = r_bits - BIT_CNT_W'(1);
                    if (leaf) begin
                        n_state = S_LEAF;
                    end else begin
                        n_node  = child[AW-1:0];
                        n_state = (r_bits == BIT_CNT_W'(1)) ? S_FETCH : S_EVAL;
                    end
                end
            end
            S_LEAF: begin
                if (out_free) begin
                    n_out       = '{kind: KIND_BYTE, data_byte: ram_rdata,
                                    status: ST_RUN, last: 1'b0};
                    n_out_valid = 1'b1;
                    n_bp        = r_bp + 24'd1;
                    n_node      = AW'(1);
                    n_state     = S_FETCH;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_out       = '{kind: KIND_STATUS, data_byte: 8'd0,
                                    status: held, last: 1'b1};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_output_size <= '0;
            r_tree_size   <= '0;
            r_node        <= AW'(1);
            r_bp          <= '0;
            r_err         <= 1'b0;
            r_err_code    <= ST_RUN;
            r_done        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_bp        <= n_bp;
            r_err       <= n_err;
            r_err_code  <= n_err_code;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OUTPUT_SIZE: r_output_size <= i_cfg_data;
                    CFG_TREE_SIZE:   r_tree_size   <= i_cfg_data[7:0];
                    default:         r_tree_size   <= r_tree_size;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_eos  <= n_eos;
        r_bits <= n_bits;
        r_out  <= n_out;
    end

endmodule

/* rtl/hbd_checker.sv */
// ----------------------------------------------------------------------------
// hbd_checker
// Port-level checks for the Huffman decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module hbd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  hbd_pkg::t_out_item o_out_data
);
    import hbd_pkg::*;

    logic [1:0] r_open;
    logic       in_xfer, out_last_xfer;

    assign in_xfer       = i_in_valid && o_in_ready;
    assign out_last_xfer = o_out_valid && i_out_ready && o_out_data.last;

    // items taken in whose status transfer has not happened yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 2'(in_xfer) - 2'(out_last_xfer);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("second transfer in before item finished");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_open != 2'd0)
        else $error("result without an open item");

    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_BYTE |-> !o_in_ready && !o_out_data.last)
        else $error("decoded byte outside a running walk");

endmodule

bind huffman_8bit_decompressor hbd_checker u_hbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* bench/tb_huffman_8bit_decompressor.sv */
// ----------------------------------------------------------------------------
// tb_huffman_8bit_decompressor
// Self-checking bench for the 8-bit Huffman decompressor. After reset the
// low part of the tree store is loaded once, and random tree sizes stay
// inside it, so that every later tree walk reads a defined entry. A table of
// directed steps then covers the header checks, completion at zero size, a
// lowered output size, the short-stream and bad-pointer errors and the
// largest tree. Random phases follow: random register settings, freshly
// built trees with random leaves, start words, random code words and stray
// items. Each result is checked field by field, typed steps against the
// table, others against an in-bench decoder; both channels get random gaps.
// ----------------------------------------------------------------------------
module tb_huffman_8bit_decompressor;
    timeunit 1ns;
    timeprecision 1ps;
    import hbd_pkg::*;

    localparam int  TREE_DEPTH = 512;
    localparam int  LOAD_DEPTH = 32;
    localparam int  KSZ_MAX    = (LOAD_DEPTH - 2) / 2;
    localparam t_op OP_UNUSED  = 2'd3;
    localparam int  SETTLE     = 8;
    localparam int  TAIL       = 200;
    localparam int  RAND_ITEMS = 140;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_op                   op;
        logic [31:0]           word;
        logic [8:0]            addr;
        logic [7:0]            byt;
        logic                  eos;
        logic                  typed;
        t_status               want;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // decoder state mirrored by the bench
    logic [7:0]  tree_copy [TREE_DEPTH];
    logic [8:0]  walk_node;
    logic [23:0] bytes_out;
    logic        halted_err;
    logic        finished;
    t_status     err_code;
    logic [23:0] size_reg;
    logic [7:0]  ksize_reg;

    t_out_item   decode_q[$];
    t_out_item   pending_q[$];
    t_out_item   due;
    t_plan_row   plan_q[$];

    bit calm;
    int n_fail;
    int n_items;
    int n_live;
    int n_cfg;
    int n_bytes;

    huffman_8bit_decompressor #(
        .TREE_DEPTH(TREE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(50_000_000);
        $display("[huffman_8bit_decompressor] ERROR");
        $finish;
    end

    function automatic t_status held_status();
        if (halted_err) return err_code;
        if (finished) return ST_DONE;
        return ST_RUN;
    endfunction

    function automatic void halt(input t_status code);
        halted_err = 1'b1;
        err_code   = code;
    endfunction

    function automatic void decode_word(input logic [31:0] w, input logic eos);
        int unsigned lim;
        int unsigned child;
        logic [7:0]  nb;
        logic        d;
        bit          stop;
        t_out_item   r;
        lim = 2 * int'(ksize_reg) + 2;
        if (lim > TREE_DEPTH) lim = TREE_DEPTH;
        stop = 1'b0;
        for (int b = 31; b >= 0 && !stop && bytes_out < size_reg; b--) begin
            if (walk_node >= lim) begin
                halt(ST_BAD_PTR);
                stop = 1'b1;
            end else begin
                d     = w[b];
                nb    = tree_copy[walk_node];
                child = walk_node + d + 2 * nb[5:0] + 2 - walk_node[0];
                if (child >= lim) begin
                    halt(ST_BAD_PTR);
                    stop = 1'b1;
                end else if (d ? nb[6] : nb[7]) begin
                    r.kind      = KIND_BYTE;
                    r.data_byte = tree_copy[child];
                    r.status    = ST_RUN;
                    r.last      = 1'b0;
                    decode_q    = {decode_q, r};
                    bytes_out++;
                    walk_node = 9'd1;
                end else begin
                    walk_node = child[8:0];
                end
            end
        end
        if (!halted_err) begin
            if (bytes_out >= size_reg) finished = 1'b1;
            else if (eos) halt(ST_SHORT);
        end
    endfunction

    function automatic void predict(input t_in_item it);
        t_out_item r;
        decode_q.delete();
        case (it.operation)
            OP_START: begin
                walk_node  = 9'd1;
                bytes_out  = '0;
                halted_err = 1'b0;
                finished   = 1'b0;
                err_code   = ST_RUN;
                if (it.header_word[7:0] != HDR_TYPE ||
                    (it.header_word[31:8] != 0 && it.header_word[31:8] != size_reg))
                    halt(ST_BAD_HDR);
                else if (size_reg == 0)
                    finished = 1'b1;
            end
            OP_TREE: begin
                if (it.tree_address < TREE_DEPTH) tree_copy[it.tree_address] = it.tree_byte;
            end
            OP_CODE: begin
                if (!halted_err && !finished) decode_word(it.code_word, it.end_of_stream);
            end
            default: ;
        endcase
        r.kind      = KIND_STATUS;
        r.data_byte = 8'h00;
        r.status    = held_status();
        r.last      = 1'b1;
        decode_q    = {decode_q, r};
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.operation     = 2'($urandom_range(0, 3));
        it.header_word   = $urandom;
        it.tree_address  = 9'($urandom_range(0, 511));
        it.tree_byte     = 8'($urandom_range(0, 255));
        it.code_word     = $urandom;
        it.end_of_stream = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic void plan_item(input t_op op, input logic [31:0] word,
                                      input logic [8:0] addr, input logic [7:0] byt,
                                      input logic eos, input logic typed,
                                      input t_status want);
        t_plan_row row;
        row        = '0;
        row.op     = op;
        row.word   = word;
        row.addr   = addr;
        row.byt    = byt;
        row.eos    = eos;
        row.typed  = typed;
        row.want   = want;
        plan_q     = {plan_q, row};
    endfunction

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        t_plan_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        plan_q     = {plan_q, row};
    endfunction

    task automatic push_item(input t_in_item it, input logic typed, input t_status want);
        t_out_item r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict(it);
        if (typed) begin
            r.kind      = KIND_STATUS;
            r.data_byte = 8'h00;
            r.status    = want;
            r.last      = 1'b1;
            pending_q   = {pending_q, r};
        end else begin
            pending_q = {pending_q, decode_q};
        end
        n_items++;
        if (it.operation != OP_UNUSED) n_live++;
    endtask

    task automatic send_tree(input int addr, input logic [7:0] val);
        t_in_item it;
        it              = rand_item();
        it.operation    = OP_TREE;
        it.tree_address = addr[8:0];
        it.tree_byte    = val;
        push_item(it, 1'b0, ST_RUN);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_OUTPUT_SIZE) size_reg = val;
        else ksize_reg = val[7:0];
        n_cfg++;
    endtask

    // breadth-first layout: children pairs allocated in order after the root
    task automatic grow_tree(input int internals, output int tree_end);
        int         open_q[$];
        int         a;
        int         p;
        int         left;
        logic [7:0] nb;
        open_q = {open_q, 1};
        left = internals - 1;
        p    = 2;
        while (open_q.size() != 0) begin
            a  = open_q.pop_front();
            nb = 8'((p - (a - a % 2) - 2) / 2);
            for (int c = 0; c < 2; c++) begin
                if (left > 0 && $urandom_range(0, 2) != 0) begin
                    open_q = {open_q, p + c};
                    left--;
                end else begin
                    nb[7 - c] = 1'b1;
                    send_tree(p + c, 8'($urandom_range(0, 255)));
                end
            end
            send_tree(a, nb);
            p += 2;
        end
        tree_end = p;
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 15) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected transfer: kind %0d data %0h status %0d last %0d",
                       o_out_data.kind, o_out_data.data_byte, o_out_data.status,
                       o_out_data.last);
                n_fail++;
            end else begin
                due = pending_q.pop_front();
                if (o_out_data.kind !== due.kind) begin
                    $error("kind expected %0d got %0d", due.kind, o_out_data.kind);
                    n_fail++;
                end
                if (o_out_data.data_byte !== due.data_byte) begin
                    $error("data_byte expected %0h got %0h", due.data_byte,
                           o_out_data.data_byte);
                    n_fail++;
                end
                if (o_out_data.status !== due.status) begin
                    $error("status expected %0d got %0d", due.status, o_out_data.status);
                    n_fail++;
                end
                if (o_out_data.last !== due.last) begin
                    $error("last expected %0d got %0d", due.last, o_out_data.last);
                    n_fail++;
                end
                if (due.kind == KIND_BYTE) n_bytes++;
            end
        end
    end

    initial begin
        t_in_item    it;
        t_plan_row   row;
        int          base;
        int          tree_end;
        int          n_words;
        logic [23:0] out_sz;
        logic [7:0]  ksz_pick;
        logic [15:0] junk;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        n_fail      = 0;
        n_items     = 0;
        n_live      = 0;
        n_cfg       = 0;
        n_bytes     = 0;
        walk_node   = 9'd1;
        bytes_out   = '0;
        halted_err  = 1'b0;
        finished    = 1'b0;
        err_code    = ST_RUN;
        size_reg    = '0;
        ksize_reg   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // load the part of the tree store that random walks can reach
        for (int a = 0; a < LOAD_DEPTH; a++) send_tree(a, 8'($urandom_range(0, 255)));

        // register defaults: zero output size, smallest tree
        plan_item(OP_CODE,   32'hFFFF_FFFF, 0, 0, 1, 1, ST_DONE);
        plan_item(OP_UNUSED, 32'h0000_0000, 0, 0, 0, 1, ST_DONE);
        plan_item(OP_START,  32'h0000_0027, 0, 0, 0, 1, ST_BAD_HDR);
        plan_item(OP_CODE,   32'h0000_0000, 0, 0, 0, 1, ST_BAD_HDR);
        plan_item(OP_START,  32'hFFFF_FF28, 0, 0, 0, 1, ST_BAD_HDR);
        plan_item(OP_START,  32'h0000_0028, 0, 0, 0, 1, ST_DONE);
        // three-leaf tree: 0 -> [2], 10 -> [4], 11 -> [5]
        plan_reg(CFG_TREE_SIZE,   24'd2);
        plan_reg(CFG_OUTPUT_SIZE, 24'd60);
        plan_item(OP_TREE,  0, 9'd1, 8'h80, 0, 0, ST_RUN);
        plan_item(OP_TREE,  0, 9'd2, 8'h00, 0, 0, ST_RUN);
        plan_item(OP_TREE,  0, 9'd3, 8'hC0, 0, 0, ST_RUN);
        plan_item(OP_TREE,  0, 9'd4, 8'hFF, 0, 0, ST_RUN);
        plan_item(OP_TREE,  0, 9'd5, 8'h5A, 0, 0, ST_RUN);
        plan_item(OP_START, 32'h0000_3C28, 0, 0, 0, 1, ST_RUN);
        plan_item(OP_CODE,  32'h7FFF_FFFF, 0, 0, 0, 0, ST_RUN);
        plan_item(OP_CODE,  32'h0000_0000, 0, 0, 0, 0, ST_RUN);
        // size dropped under the byte count
        plan_reg(CFG_OUTPUT_SIZE, 24'd20);
        plan_item(OP_CODE,  32'h1234_5678, 0, 0, 0, 1, ST_DONE);
        // walk left inside the tree, then the tree shrinks under it
        plan_reg(CFG_OUTPUT_SIZE, 24'd60);
        plan_item(OP_START, 32'h0000_0028, 0, 0, 0, 1, ST_RUN);
        plan_item(OP_CODE,  32'h7FFF_FFFF, 0, 0, 0, 0, ST_RUN);
        plan_reg(CFG_TREE_SIZE,   24'hFFFF00);
        plan_item(OP_CODE,  32'hFFFF_FFFF, 0, 0, 0, 1, ST_BAD_PTR);
        // last word arrives before enough bytes
        plan_reg(CFG_TREE_SIZE,   24'd2);
        plan_item(OP_START, 32'h0000_3C28, 0, 0, 0, 1, ST_RUN);
        plan_item(OP_CODE,  32'hAAAA_AAAA, 0, 0, 1, 0, ST_RUN);
        plan_item(OP_CODE,  32'h0000_0000, 0, 0, 0, 1, ST_SHORT);
        // largest tree: a chain of far pointers runs off the end of the store
        plan_reg(CFG_TREE_SIZE,   24'd255);
        plan_item(OP_TREE,  0, 9'd1,   8'h3F, 0, 0, ST_RUN);
        plan_item(OP_TREE,  0, 9'd128, 8'h3F, 0, 0, ST_RUN);
        plan_item(OP_TREE,  0, 9'd256, 8'h3F, 0, 0, ST_RUN);
        plan_item(OP_TREE,  0, 9'd384, 8'h3F, 0, 0, ST_RUN);
        plan_item(OP_START, 32'h0000_0028, 0, 0, 0, 1, ST_RUN);
        plan_item(OP_CODE,  32'h0000_0000, 0, 0, 0, 1, ST_BAD_PTR);

        foreach (plan_q[i]) begin
            row = plan_q[i];
            if (row.is_cfg) begin
                write_reg(row.idx, row.val);
            end else begin
                it           = rand_item();
                it.operation = row.op;
                if (row.op == OP_START) it.header_word = row.word;
                if (row.op == OP_CODE) begin
                    it.code_word     = row.word;
                    it.end_of_stream = row.eos;
                end
                if (row.op == OP_TREE) begin
                    it.tree_address = row.addr;
                    it.tree_byte    = row.byt;
                end
                push_item(it, row.typed, row.want);
            end
        end

        base = n_live;
        while (n_live - base < RAND_ITEMS) begin
            calm = (n_live - base >= RAND_ITEMS * 4 / 5);
            case ($urandom_range(0, 9))
                0:       out_sz = '0;
                1:       out_sz = 24'hFF_FFFF;
                default: out_sz = 24'($urandom_range(1, 48));
            endcase
            write_reg(CFG_OUTPUT_SIZE, out_sz);
            tree_end = 0;
            if ($urandom_range(0, 3) != 0) grow_tree($urandom_range(1, 10), tree_end);
            // tree end stays inside the loaded part of the store
            case ($urandom_range(0, 7))
                0:       ksz_pick = 8'($urandom_range(0, KSZ_MAX));
                1:       ksz_pick = 8'(KSZ_MAX);
                default: ksz_pick = (tree_end > 2) ? 8'((tree_end - 2) / 2)
                                                   : 8'($urandom_range(0, KSZ_MAX));
            endcase
            junk = 16'($urandom);
            write_reg(CFG_TREE_SIZE, {junk, ksz_pick});
            // a phase without a start keeps the walk of the one before
            if ($urandom_range(0, 3) != 0) begin
                it           = rand_item();
                it.operation = OP_START;
                case ($urandom_range(0, 5))
                    0:       ;
                    1:       it.header_word[7:0] = HDR_TYPE;
                    2:       it.header_word = {24'd0, HDR_TYPE};
                    default: it.header_word = {out_sz, HDR_TYPE};
                endcase
                push_item(it, 1'b0, ST_RUN);
            end
            n_words = $urandom_range(1, 6);
            for (int w = 0; w < n_words; w++) begin
                if ($urandom_range(0, 7) == 0) push_item(rand_item(), 1'b0, ST_RUN);
                it               = rand_item();
                it.operation     = OP_CODE;
                it.end_of_stream = (w == n_words - 1) ? 1'($urandom_range(0, 1)) : 1'b0;
                push_item(it, 1'b0, ST_RUN);
            end
        end

        settle();
        repeat (TAIL) @(posedge i_clk);
        $display("Sent %0d input transfers (%0d acted on) and %0d register writes;",
                 n_items, n_live, n_cfg);
        $display("checked %0d decoded bytes along with a status for every item.",
                 n_bytes);
        if (n_fail == 0) begin
            $display("[huffman_8bit_decompressor] OK");
        end else begin
            $display("[huffman_8bit_decompressor] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/hbd_pkg.sv
rtl/hbd_ram.sv
rtl/huffman_8bit_decompressor.sv
rtl/hbd_checker.sv
bench/tb_huffman_8bit_decompressor.sv
